>>> rtl/utfac_pkg.sv
// Package for the UTF-8 decoder with accent composition.
// Holds widths, byte classes, accent codes, queue entry types and the composition helpers.
// No dependencies; used by every module in rtl/ except utfac_fifo.
package utfac_pkg;

   // Widths
   localparam int CP_W   = 21;
   localparam int BYTE_W = 8;
   localparam int ACC_W  = 3;

   // Default depth of the internal queues
   localparam int UTFAC_QUEUE_DEPTH = 4;

   // Lead byte thresholds
   localparam logic [BYTE_W-1:0] LEAD4_MIN = 8'hF0;
   localparam logic [BYTE_W-1:0] LEAD3_MIN = 8'hE0;
   localparam logic [BYTE_W-1:0] LEAD2_MIN = 8'hC0;

   // Combining accents
   localparam logic [CP_W-1:0] CP_GRAVE      = 21'h000300;
   localparam logic [CP_W-1:0] CP_ACUTE      = 21'h000301;
   localparam logic [CP_W-1:0] CP_CIRCUMFLEX = 21'h000302;
   localparam logic [CP_W-1:0] CP_TILDE      = 21'h000303;
   localparam logic [CP_W-1:0] CP_DIAERESIS  = 21'h000308;

   // Accent indices within a vowel's precomposed row
   localparam logic [ACC_W-1:0] ACC_GRAVE      = 3'd0;
   localparam logic [ACC_W-1:0] ACC_ACUTE      = 3'd1;
   localparam logic [ACC_W-1:0] ACC_CIRCUMFLEX = 3'd2;
   localparam logic [ACC_W-1:0] ACC_TILDE      = 3'd3;
   localparam logic [ACC_W-1:0] ACC_DIAERESIS  = 3'd4;

   // Latin-1 base of each upper-case vowel row
   localparam logic [7:0] ROW_A = 8'hC0;
   localparam logic [7:0] ROW_E = 8'hC8;
   localparam logic [7:0] ROW_I = 8'hCC;
   localparam logic [7:0] ROW_O = 8'hD2;
   localparam logic [7:0] ROW_U = 8'hD9;
   localparam logic [7:0] LOWER_OFFSET = 8'd32;

   // Decoded character passed from front to back
   typedef struct packed {
      logic [CP_W-1:0] code_point;
      logic            has_char;
      logic            end_of_text;
      logic            truncated;
   } char_event_type;

   // Result entry waiting on the response side
   typedef struct packed {
      logic [CP_W-1:0] code_point;
      logic            has_char;
      logic            last_of_text;
      logic            truncated;
   } result_type;

   // Map a code point to {is_accent, accent index}
   function automatic logic [ACC_W:0] accent_lookup(input logic [CP_W-1:0] cp);
      logic [ACC_W:0] res;
      case (cp)
         CP_GRAVE:      res = {1'b1, ACC_GRAVE};
         CP_ACUTE:      res = {1'b1, ACC_ACUTE};
         CP_CIRCUMFLEX: res = {1'b1, ACC_CIRCUMFLEX};
         CP_TILDE:      res = {1'b1, ACC_TILDE};
         CP_DIAERESIS:  res = {1'b1, ACC_DIAERESIS};
         default:       res = {1'b0, ACC_GRAVE};
      endcase
      return res;
   endfunction

   // Compose a plain vowel with an accent; returns {ok, composed code point}
   function automatic logic [CP_W:0] compose_vowel(input logic [CP_W-1:0] base_ch,
                                                   input logic [ACC_W-1:0] acc);
      logic       ok;
      logic       lower;
      logic       no_tilde;
      logic [7:0] row;
      logic [7:0] r;
      ok       = (base_ch[CP_W-1:8] == '0);
      lower    = 1'b0;
      no_tilde = 1'b0;
      row      = ROW_A;
      case (base_ch[7:0])
         8'h41: row = ROW_A;                                   // A
         8'h61: begin row = ROW_A; lower = 1'b1; end           // a
         8'h45: begin row = ROW_E; no_tilde = 1'b1; end        // E
         8'h65: begin row = ROW_E; no_tilde = 1'b1; lower = 1'b1; end
         8'h49: begin row = ROW_I; no_tilde = 1'b1; end        // I
         8'h69: begin row = ROW_I; no_tilde = 1'b1; lower = 1'b1; end
         8'h4F: row = ROW_O;                                   // O
         8'h6F: begin row = ROW_O; lower = 1'b1; end           // o
         8'h55: begin row = ROW_U; no_tilde = 1'b1; end        // U
         8'h75: begin row = ROW_U; no_tilde = 1'b1; lower = 1'b1; end
         default: ok = 1'b0;
      endcase
      r = row + (lower ? LOWER_OFFSET : 8'd0) + {5'b0, acc};
      // rows without a tilde form put the diaeresis one slot earlier
      if (no_tilde && (acc == ACC_DIAERESIS)) begin
         r = r - 8'd1;
      end
      return {ok, {(CP_W-8){1'b0}}, r};
   endfunction

endpackage

>>> rtl/utfac_fifo.sv
// Small register-based queue used between the decoder stages and at the response side.
// Depends on nothing; width and depth come from the instantiating module.
module utfac_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty,
   output logic             full
);
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign empty    = (count_ff == '0);
   assign full     = (count_ff == CW'(DEPTH));
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = slot_ff[rd_ptr_ff];

   // Advance pointers with wrap at the depth
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({do_push, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   // Hold control state
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store payload
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> rtl/utfac_front.sv
// Front stage: gathers UTF-8 bytes into code points and flags end of text.
// Depends on utfac_pkg; feeds the character queue read by utfac_back.
module utfac_front (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         byte_accept,
   input  logic [utfac_pkg::BYTE_W-1:0] text_byte,
   input  logic                         end_of_text,
   output logic                         event_push,
   output utfac_pkg::char_event_type    event_data
);
   import utfac_pkg::*;

   logic [CP_W-1:0] partial_ff, partial_in;
   logic [1:0]      pending_ff, pending_in;
   logic [1:0]      pending_dec;
   logic            done;
   logic [CP_W-1:0] cp;

   // Classify the byte and merge continuation bits
   always_comb begin
      partial_in  = partial_ff;
      pending_in  = pending_ff;
      pending_dec = pending_ff - 2'd1;
      done        = 1'b0;
      cp          = '0;
      if (pending_ff != 2'd0) begin
         case (pending_dec)
            2'd0:    partial_in = partial_ff | {15'b0, text_byte[5:0]};
            2'd1:    partial_in = partial_ff | {9'b0, text_byte[5:0], 6'b0};
            default: partial_in = partial_ff | {3'b0, text_byte[5:0], 12'b0};
         endcase
         pending_in = pending_dec;
         if (pending_dec == 2'd0) begin
            done = 1'b1;
            cp   = partial_in;
         end
      end else if (text_byte >= LEAD4_MIN) begin
         partial_in = {text_byte[2:0], 18'b0};
         pending_in = 2'd3;
      end else if (text_byte >= LEAD3_MIN) begin
         partial_in = {5'b0, text_byte[3:0], 12'b0};
         pending_in = 2'd2;
      end else if (text_byte >= LEAD2_MIN) begin
         partial_in = {10'b0, text_byte[4:0], 6'b0};
         pending_in = 2'd1;
      end else begin
         done = 1'b1;
         cp   = {13'b0, text_byte};
      end
   end

   // Hand a finished character or an end marker to the back stage
   always_comb begin
      event_push             = byte_accept && (done || end_of_text);
      event_data.code_point  = cp;
      event_data.has_char    = done;
      event_data.end_of_text = end_of_text;
      event_data.truncated   = end_of_text && (pending_in != 2'd0);
   end

   // Advance sequence state; drop it at end of text
   always_ff @(posedge clock) begin
      if (reset) begin
         partial_ff <= '0;
         pending_ff <= 2'd0;
      end else if (byte_accept) begin
         if (end_of_text) begin
            partial_ff <= '0;
            pending_ff <= 2'd0;
         end else begin
            partial_ff <= partial_in;
            pending_ff <= pending_in;
         end
      end
   end

endmodule

>>> rtl/utfac_back.sv
// Back stage: holds one character, composes accents onto vowels and emits results.
// Depends on utfac_pkg; reads the character queue and writes the response queue.
module utfac_back (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      event_empty,
   input  utfac_pkg::char_event_type event_data,
   output logic                      event_pop,
   input  logic                      result_full,
   output logic                      result_push,
   output utfac_pkg::result_type     result_data
);
   import utfac_pkg::*;

   logic [CP_W-1:0] held_ff, held_in;
   logic            held_valid_ff, held_valid_in;
   logic            phase_ff, phase_in;

   logic [ACC_W:0]  acc_info;
   logic [CP_W:0]   comp_info;
   logic            go;
   logic            char_active;
   logic            is_merge;
   logic            char_emit;
   logic            split;
   logic [CP_W-1:0] held_mid;
   logic            valid_mid;

   assign acc_info  = accent_lookup(event_data.code_point);
   assign comp_info = compose_vowel(held_ff, acc_info[ACC_W-1:0]);

   // Work out the character part, then the end-of-text part
   always_comb begin
      go          = !event_empty && !result_full;
      char_active = event_data.has_char && !phase_ff;
      is_merge    = char_active && acc_info[ACC_W] && held_valid_ff;
      char_emit   = char_active && !is_merge && held_valid_ff;
      split       = char_emit && event_data.end_of_text;

      held_mid  = held_ff;
      valid_mid = held_valid_ff || char_active;
      if (is_merge) begin
         if (comp_info[CP_W]) begin
            held_mid = comp_info[CP_W-1:0];
         end
      end else if (char_active) begin
         held_mid = event_data.code_point;
      end

      result_push = go && (char_emit || event_data.end_of_text);
      if (char_emit) begin
         result_data.code_point   = held_ff;
         result_data.has_char     = 1'b1;
         result_data.last_of_text = 1'b0;
         result_data.truncated    = 1'b0;
      end else begin
         result_data.code_point   = valid_mid ? held_mid : '0;
         result_data.has_char     = valid_mid;
         result_data.last_of_text = 1'b1;
         result_data.truncated    = event_data.truncated;
      end

      // a flush that also releases the held character takes a second pass
      event_pop     = go && !split;
      phase_in      = phase_ff;
      held_in       = held_ff;
      held_valid_in = held_valid_ff;
      if (go) begin
         if (split) begin
            phase_in      = 1'b1;
            held_in       = held_mid;
            held_valid_in = valid_mid;
         end else begin
            phase_in = 1'b0;
            if (event_data.end_of_text) begin
               held_in       = '0;
               held_valid_in = 1'b0;
            end else begin
               held_in       = held_mid;
               held_valid_in = valid_mid;
            end
         end
      end
   end

   // Hold the pending character and flush phase
   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff       <= '0;
         held_valid_ff <= 1'b0;
         phase_ff      <= 1'b0;
      end else begin
         held_ff       <= held_in;
         held_valid_ff <= held_valid_in;
         phase_ff      <= phase_in;
      end
   end

`ifndef SYNTH
   // second flush pass keeps its queue entry at the head
   a_phase_has_event: assert property (@(posedge clock) disable iff (reset)
      phase_ff |-> !event_empty)
      else $error("flush phase set with empty character queue");

   // second flush pass always has a held character to emit
   a_phase_has_held: assert property (@(posedge clock) disable iff (reset)
      phase_ff |-> held_valid_ff)
      else $error("flush phase set with nothing held");

   // never write into a full response queue
   a_push_room: assert property (@(posedge clock) disable iff (reset)
      result_push |-> !result_full)
      else $error("result pushed into full queue");

   // a completed end of text leaves nothing held
   a_flush_clears: assert property (@(posedge clock) disable iff (reset)
      (event_pop && event_data.end_of_text) |=> !held_valid_ff)
      else $error("held character survived end of text");
`endif

endmodule

>>> rtl/utf8_decode_accent_compose_unit.sv
// Top level of the UTF-8 decoder with combining-accent composition.
// Depends on utfac_pkg, utfac_fifo, utfac_front and utfac_back.
//
// Usage:
//   Requests are UTF-8 bytes written like a queue: drive req_text_byte and
//   req_end_of_text, raise req_push; the byte is taken on an edge where
//   req_full is low. Results are read like a queue: while rsp_empty is low
//   the oldest result is on the rsp_ ports, and it leaves on an edge where
//   rsp_pop is high.
//   Throughput: one byte per cycle while req_full stays low. An end-of-text byte
//   that both releases the held character and closes the text yields two
//   results and holds the composer for a second pass.
//   Path: a byte that releases a result is written into the character queue;
//   the composer reads it from the head of that queue and writes the result
//   into the response queue, whose head drives the rsp_ ports. One character
//   is always held back for accent composition, so a plain character appears
//   only when the next non-accent character or the end of text arrives.
//   Stall: if rsp_pop stays low the response queue fills, the composer stops,
//   the character queue fills and req_full rises; nothing is lost.
//   Reset: synchronous, active high; it empties both queues, drops any open
//   sequence and the held character.
module utf8_decode_accent_compose_unit #(
   parameter int QUEUE_DEPTH = utfac_pkg::UTFAC_QUEUE_DEPTH
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_push,
   output logic                         req_full,
   input  logic [utfac_pkg::BYTE_W-1:0] req_text_byte,
   input  logic                         req_end_of_text,
   output logic                         rsp_empty,
   input  logic                         rsp_pop,
   output logic [utfac_pkg::CP_W-1:0]   rsp_code_point,
   output logic                         rsp_has_char,
   output logic                         rsp_last_of_text,
   output logic                         rsp_truncated
);
   import utfac_pkg::*;

   logic           byte_accept;
   logic           event_push;
   char_event_type event_in;
   char_event_type event_head;
   logic           event_pop;
   logic           event_empty;
   logic           event_full;
   logic           result_push;
   result_type     result_in;
   result_type     result_head;
   logic           result_full;

   assign req_full    = event_full;
   assign byte_accept = req_push && !event_full;

   // Decode bytes into characters
   utfac_front u_front (
      .clock       (clock),
      .reset       (reset),
      .byte_accept (byte_accept),
      .text_byte   (req_text_byte),
      .end_of_text (req_end_of_text),
      .event_push  (event_push),
      .event_data  (event_in)
   );

   // Queue characters between front and back
   utfac_fifo #(
      .WIDTH ($bits(char_event_type)),
      .DEPTH (QUEUE_DEPTH)
   ) u_char_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (event_push),
      .push_data (event_in),
      .pop       (event_pop),
      .pop_data  (event_head),
      .empty     (event_empty),
      .full      (event_full)
   );

   // Compose accents and emit results
   utfac_back u_back (
      .clock       (clock),
      .reset       (reset),
      .event_empty (event_empty),
      .event_data  (event_head),
      .event_pop   (event_pop),
      .result_full (result_full),
      .result_push (result_push),
      .result_data (result_in)
   );

   // Queue results for the receiver
   utfac_fifo #(
      .WIDTH ($bits(result_type)),
      .DEPTH (QUEUE_DEPTH)
   ) u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (result_push),
      .push_data (result_in),
      .pop       (rsp_pop),
      .pop_data  (result_head),
      .empty     (rsp_empty),
      .full      (result_full)
   );

   assign rsp_code_point   = result_head.code_point;
   assign rsp_has_char     = result_head.has_char;
   assign rsp_last_of_text = result_head.last_of_text;
   assign rsp_truncated    = result_head.truncated;

endmodule

>>> tb/utfac_result_checker.sv
`timescale 1ns / 100ps
// Result checker for utf8_decode_accent_compose_unit: follows every accepted request, predicts
// the decoded and composed characters and compares them with each popped result.
// Depends on utfac_pkg for the widths, lead byte limits, accent codes and result_type.
module utfac_result_checker (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_push,
   input  logic                         req_full,
   input  logic [utfac_pkg::BYTE_W-1:0] req_text_byte,
   input  logic                         req_end_of_text,
   input  logic                         rsp_empty,
   input  logic                         rsp_pop,
   input  logic [utfac_pkg::CP_W-1:0]   rsp_code_point,
   input  logic                         rsp_has_char,
   input  logic                         rsp_last_of_text,
   input  logic                         rsp_truncated,
   output int                           mismatch_count,
   output int                           outstanding
);
   import utfac_pkg::*;

   localparam int REPORT_LIMIT = 10;

   // Decoder and composer state
   logic [CP_W-1:0] held_cp  = '0;
   logic            held_ok  = 1'b0;
   logic [CP_W-1:0] seq_bits = '0;
   logic [1:0]      seq_left = '0;
   result_type      expected_chars[$];

   // Classify a code point as one of the five combining accents
   function automatic logic accent_of(input logic [CP_W-1:0] cp,
                                      output logic [ACC_W-1:0] slot);
      accent_of = 1'b1;
      slot      = ACC_GRAVE;
      case (cp)
         CP_GRAVE:      slot = ACC_GRAVE;
         CP_ACUTE:      slot = ACC_ACUTE;
         CP_CIRCUMFLEX: slot = ACC_CIRCUMFLEX;
         CP_TILDE:      slot = ACC_TILDE;
         CP_DIAERESIS:  slot = ACC_DIAERESIS;
         default:       accent_of = 1'b0;
      endcase
   endfunction

   // Merge a plain vowel with an accent into its Latin-1 letter
   function automatic logic try_compose(input logic [CP_W-1:0] base,
                                        input logic [ACC_W-1:0] slot,
                                        output logic [CP_W-1:0] composed);
      int   sum;
      logic lacks_tilde;
      logic [7:0] row;
      try_compose = 1'b1;
      lacks_tilde = 1'b0;
      row         = ROW_A;
      composed    = base;
      case (base)
         21'h41, 21'h61: row = ROW_A;
         21'h45, 21'h65: begin
            row = ROW_E;
            lacks_tilde = 1'b1;
         end
         21'h49, 21'h69: begin
            row = ROW_I;
            lacks_tilde = 1'b1;
         end
         21'h4F, 21'h6F: row = ROW_O;
         21'h55, 21'h75: begin
            row = ROW_U;
            lacks_tilde = 1'b1;
         end
         default: try_compose = 1'b0;
      endcase
      // lower case letters carry bit 5, and their row sits 32 above
      sum = int'(row);
      sum = sum + (base[5] ? 32 : 0) + int'(slot);
      // e, i and u have no tilde form, so the diaeresis slides down one
      if (lacks_tilde && (slot == ACC_DIAERESIS)) begin
         sum = sum - 1;
      end
      if (try_compose) begin
         composed = CP_W'(sum);
      end
   endfunction

   task automatic queue_char(input logic [CP_W-1:0] cp, input logic has,
                             input logic last, input logic trunc);
      result_type r;
      r.code_point   = has ? cp : '0;
      r.has_char     = has;
      r.last_of_text = last;
      r.truncated    = trunc;
      expected_chars = {expected_chars, r};
   endtask

   // Advance the decoder by one byte and queue the characters it releases
   task automatic decode_and_compose(input logic [BYTE_W-1:0] b, input logic eot);
      logic [CP_W-1:0]  ch;
      logic [CP_W-1:0]  comp;
      logic [ACC_W-1:0] slot;
      logic             got;
      ch  = '0;
      got = 1'b0;
      if (seq_left != 0) begin
         // any byte inside an open sequence counts as a continuation
         seq_left = seq_left - 2'd1;
         seq_bits = seq_bits | (CP_W'(b[5:0]) << (6 * seq_left));
         if (seq_left == 0) begin
            ch  = seq_bits;
            got = 1'b1;
         end
      end else if (b >= LEAD4_MIN) begin
         seq_bits = CP_W'(b[2:0]) << 18;
         seq_left = 2'd3;
      end else if (b >= LEAD3_MIN) begin
         seq_bits = CP_W'(b[3:0]) << 12;
         seq_left = 2'd2;
      end else if (b >= LEAD2_MIN) begin
         seq_bits = CP_W'(b[4:0]) << 6;
         seq_left = 2'd1;
      end else begin
         ch  = CP_W'(b);
         got = 1'b1;
      end

      if (got) begin
         if (accent_of(ch, slot) && held_ok) begin
            // compose onto a plain vowel, otherwise drop the accent
            if (try_compose(held_cp, slot, comp)) begin
               held_cp = comp;
            end
         end else begin
            if (held_ok) begin
               queue_char(held_cp, 1'b1, 1'b0, 1'b0);
            end
            held_cp = ch;
            held_ok = 1'b1;
         end
      end

      // flush at end of text and start clean
      if (eot) begin
         queue_char(held_cp, held_ok, 1'b1, seq_left != 0);
         held_cp  = '0;
         held_ok  = 1'b0;
         seq_bits = '0;
         seq_left = '0;
      end
   endtask

   // Compare one popped result with the oldest expected character
   task automatic check_result();
      result_type want;
      if (expected_chars.size() == 0) begin
         if (mismatch_count < REPORT_LIMIT) begin
            $display("unexpected result: cp=%06h has=%0b last=%0b trunc=%0b",
                     rsp_code_point, rsp_has_char, rsp_last_of_text, rsp_truncated);
         end
         mismatch_count++;
      end else begin
         want = expected_chars.pop_front();
         if (want.code_point !== rsp_code_point || want.has_char !== rsp_has_char ||
             want.last_of_text !== rsp_last_of_text || want.truncated !== rsp_truncated) begin
            if (mismatch_count < REPORT_LIMIT) begin
               $display("mismatch: expected cp=%06h has=%0b last=%0b trunc=%0b",
                        want.code_point, want.has_char, want.last_of_text, want.truncated);
               $display("          actual   cp=%06h has=%0b last=%0b trunc=%0b",
                        rsp_code_point, rsp_has_char, rsp_last_of_text, rsp_truncated);
            end
            mismatch_count++;
         end
      end
   endtask

   // Check results before predicting: a request never releases a result on its own edge
   always @(posedge clock) begin
      if (reset) begin
         expected_chars.delete();
         held_cp  = '0;
         held_ok  = 1'b0;
         seq_bits = '0;
         seq_left = '0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            check_result();
         end
         if (req_push && !req_full) begin
            decode_and_compose(req_text_byte, req_end_of_text);
         end
      end
      outstanding = expected_chars.size();
   end

endmodule

>>> tb/testbench.sv
`timescale 1ns / 100ps
// Top of the testbench for utf8_decode_accent_compose_unit: clock, reset, byte stimulus,
// result pop pacing, watchdog and verdict. Depends on utfac_pkg and utfac_result_checker.
module testbench;
   import utfac_pkg::*;

   localparam int ITEM_TARGET    = 1700;
   localparam int RESET_CYCLES   = 4;
   localparam int SETTLE_CYCLES  = 8;
   localparam int LONG_HOLD      = 300;
   localparam int PRESSURE_TEXT  = 12;
   localparam int WATCHDOG_LIMIT = 3000;

   logic              clock           = 1'b0;
   logic              reset           = 1'b1;
   logic              req_push        = 1'b0;
   logic [BYTE_W-1:0] req_text_byte   = '0;
   logic              req_end_of_text = 1'b0;
   logic              rsp_pop         = 1'b0;
   logic              req_full;
   logic              rsp_empty;
   logic [CP_W-1:0]   rsp_code_point;
   logic              rsp_has_char;
   logic              rsp_last_of_text;
   logic              rsp_truncated;
   int                mismatch_count;
   int                outstanding;

   int   idle_cycles  = 0;
   int   sent_count   = 0;
   logic no_idle      = 1'b0;
   logic hold_request = 1'b0;
   logic hold_active  = 1'b0;

   logic [7:0] text_bytes[$];
   logic [7:0] vowel_set[10]  = '{8'h61, 8'h65, 8'h69, 8'h6F, 8'h75,
                                  8'h41, 8'h45, 8'h49, 8'h4F, 8'h55};
   // second bytes of CC xx for grave, acute, circumflex, tilde, diaeresis
   logic [7:0] accent_tail[5] = '{8'h80, 8'h81, 8'h82, 8'h83, 8'h88};

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   utf8_decode_accent_compose_unit u_top (.*);

   utfac_result_checker u_checker (.*);

   // Count cycles in which neither side moves a request or a result
   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin : watchdog
      wait (idle_cycles >= WATCHDOG_LIMIT);
      $display("TB_ERROR");
      $finish;
   end

   // Mostly no gap, often a short one, now and then a long one
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Pace pops in bursts and gaps; hold off for a long stretch on request
   initial begin : pop_driver
      int run;
      int gap;
      forever begin
         if (hold_request) begin
            hold_request = 1'b0;
            hold_active  = 1'b1;
            @(negedge clock) rsp_pop <= 1'b0;
            repeat (LONG_HOLD) @(negedge clock);
            hold_active = 1'b0;
         end
         run = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 8);
         repeat (run) @(negedge clock) rsp_pop <= 1'b1;
         gap = pick_gap();
         repeat (gap) @(negedge clock) rsp_pop <= 1'b0;
      end
   end

   // Offer one byte and hold it until the block takes the request
   task automatic send_request(input logic [7:0] b, input logic eot);
      int gap;
      gap = no_idle ? 0 : pick_gap();
      repeat (gap) @(negedge clock) req_push <= 1'b0;
      @(negedge clock);
      req_push        <= 1'b1;
      req_text_byte   <= b;
      req_end_of_text <= eot;
      do @(posedge clock); while (req_full);
      sent_count++;
   endtask

   task automatic send_text();
      foreach (text_bytes[i]) begin
         send_request(text_bytes[i], i == text_bytes.size() - 1);
      end
      text_bytes.delete();
   endtask

   // Stop offering, wait for every expected result, then let the pipeline settle
   task automatic drain_results();
      @(negedge clock) req_push <= 1'b0;
      wait (outstanding == 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Append one byte to the text being built
   task automatic add_byte(input logic [7:0] b);
      text_bytes = {text_bytes, b};
   endtask

   // Append a combining accent in one of its encodings, or a near miss
   task automatic add_accent();
      int pick;
      logic [7:0] tail;
      tail = accent_tail[$urandom_range(0, 4)];
      pick = $urandom_range(0, 19);
      if (pick < 13) begin
         add_byte(8'hCC);
         add_byte(tail);
      end else if (pick < 15) begin
         // only the low six bits of a continuation count
         add_byte(8'hCC);
         add_byte(tail ^ 8'hC0);
      end else if (pick < 17) begin
         // overlong three-byte form of the same accent
         add_byte(8'hE0);
         add_byte(8'h8C);
         add_byte(tail);
      end else begin
         add_byte($urandom_range(0, 1) ? 8'hCC : 8'hCD);
         add_byte(8'($urandom_range(8'h84, 8'h8F)));
      end
   endtask

   task automatic add_sequence(input int lead_lo, input int lead_hi, input int cont);
      add_byte(8'($urandom_range(lead_lo, lead_hi)));
      repeat (cont) add_byte(8'($urandom_range(0, 255)));
   endtask

   // Append one character-sized piece of text, mostly vowels and accents
   task automatic add_token();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
         add_byte(vowel_set[$urandom_range(0, 9)]);
         repeat ($urandom_range(0, 2)) add_accent();
      end else if (pick < 45) begin
         add_accent();
      end else if (pick < 60) begin
         add_byte(8'($urandom_range(0, 127)));
         if ($urandom_range(0, 3) == 0) add_accent();
      end else if (pick < 68) begin
         add_byte(8'($urandom_range(0, 255)));
      end else if (pick < 78) begin
         add_sequence(8'hC0, 8'hDF, 1);
      end else if (pick < 88) begin
         add_sequence(8'hE0, 8'hEF, 2);
      end else begin
         add_sequence(8'hF0, 8'hFF, 3);
      end
   endtask

   // Append a lead byte with fewer continuations than it needs
   task automatic add_cut_sequence();
      int need;
      need = $urandom_range(1, 3);
      case (need)
         1:       add_sequence(8'hC0, 8'hDF, 0);
         2:       add_sequence(8'hE0, 8'hEF, $urandom_range(0, 1));
         default: add_sequence(8'hF0, 8'hFF, $urandom_range(0, 2));
      endcase
   endtask

   task automatic build_random_text();
      int tokens;
      tokens = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 10);
      repeat (tokens) add_token();
      if (tokens == 0 || $urandom_range(0, 6) == 0) add_cut_sequence();
   endtask

   initial begin : stimulus
      int text_count;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      // every accent on vowels of both cases, tilde on e, diaeresis on U
      add_byte(8'h61); add_byte(8'hCC); add_byte(8'h80);
      add_byte(8'h45); add_byte(8'hCC); add_byte(8'h81);
      add_byte(8'h69); add_byte(8'hCC); add_byte(8'h82);
      add_byte(8'h4F); add_byte(8'hCC); add_byte(8'h83);
      add_byte(8'h55); add_byte(8'hCC); add_byte(8'h88);
      add_byte(8'h65); add_byte(8'hCC); add_byte(8'h83);
      send_text();
      // accent with nothing held, accent after an accent, zero byte, top lead byte
      add_byte(8'hCC); add_byte(8'h81);
      add_byte(8'hCC); add_byte(8'h88);
      add_byte(8'h00);
      add_byte(8'hFF); add_byte(8'h80);
      add_byte(8'h80); add_byte(8'hBF);
      send_text();
      // text ends inside a sequence with nothing held
      add_byte(8'hE2); add_byte(8'h82);
      send_text();
      drain_results();

      // random texts; one of them runs into a long pop hold-off
      text_count = 0;
      while (sent_count < ITEM_TARGET) begin
         text_count++;
         no_idle = ($urandom_range(0, 4) == 0);
         if (text_count == PRESSURE_TEXT) begin
            drain_results();
            hold_request = 1'b1;
            wait (hold_active);
            no_idle = 1'b1;
            repeat (40) add_token();
            send_text();
            drain_results();
         end else begin
            build_random_text();
            send_text();
            if ($urandom_range(0, 7) == 0) drain_results();
         end
      end
      drain_results();

      if (mismatch_count == 0 && outstanding == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
